>>> sv/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants of the call latency statistics block
// Field widths, action and statistic codes, the queue entry and the
// helpers that fold one sample into a set of running moments.
// ----------------------------------------------------------------------------
package cls_pkg;

    localparam int ACTION_W   = 3;
    localparam int SLOT_W     = 8;
    localparam int TICKS_W    = 32;
    localparam int BYTES_W    = 20;
    localparam int KIND_W     = 3;
    localparam int SEL_W      = 8;
    localparam int VALUE_W    = 64;
    localparam int BYTES_SQ_W = 2 * BYTES_W;
    localparam int TICKS_SQ_W = 2 * TICKS_W;

    // Wide enough for a bin index at the largest supported histogram size.
    localparam int BIN_IDX_W  = 12;
    // Offset of a kind counter within the kind statistic range.
    localparam int KIND_SEL_W = 7;

    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_CALL_SLOTS     = 256;
    localparam int DEF_HIST_BINS      = 64;
    localparam int DEF_BIN_WIDTH      = 16;
    localparam int DEF_RESPONSE_KINDS = 8;

    localparam logic [ACTION_W-1:0] ACT_SEND_START = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND_STOP  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RECV_START = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RECV_STOP  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;

    localparam logic [SEL_W-1:0] SEL_REQ_TOTAL = 8'd0;
    localparam logic [SEL_W-1:0] SEL_REQ_BYTES = 8'd1;
    localparam logic [SEL_W-1:0] SEL_REQ_XFER  = 8'd5;
    localparam logic [SEL_W-1:0] SEL_RESP_TIME = 8'd9;
    localparam logic [SEL_W-1:0] SEL_RSP_TOTAL = 8'd13;
    localparam logic [SEL_W-1:0] SEL_RSP_BYTES = 8'd14;
    localparam logic [SEL_W-1:0] SEL_RSP_XFER  = 8'd18;
    localparam logic [SEL_W-1:0] SEL_GROUP_END = 8'd3;
    localparam logic [SEL_W-1:0] SEL_BIN_BASE  = 8'd64;
    localparam logic [SEL_W-1:0] SEL_BIN_END   = 8'd127;
    localparam logic [SEL_W-1:0] SEL_KIND_BASE = 8'd128;
    localparam logic [SEL_W-1:0] SEL_KIND_END  = 8'd255;

    localparam logic [1:0] MOM_SUM        = 2'd0;
    localparam logic [1:0] MOM_SQUARE_SUM = 2'd1;
    localparam logic [1:0] MOM_LEAST      = 2'd2;
    localparam logic [1:0] MOM_MOST       = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [TICKS_W-1:0]    dt;
        logic [TICKS_SQ_W-1:0] dt_sq;
        logic [BYTES_W-1:0]    bytes;
        logic [BYTES_SQ_W-1:0] bytes_sq;
        logic [KIND_W-1:0]     kind;
        logic [SEL_W-1:0]      sel;
        logic [BIN_IDX_W-1:0]  bin;
    } op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sum;
        logic [VALUE_W-1:0] square_sum;
        logic [BYTES_W-1:0] least;
        logic [BYTES_W-1:0] most;
    } byte_mom_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sum;
        logic [VALUE_W-1:0] square_sum;
        logic [TICKS_W-1:0] least;
        logic [TICKS_W-1:0] most;
    } tick_mom_t;

    localparam byte_mom_t BYTE_MOM_RESET = '{sum: '0, square_sum: '0, least: '1, most: '0};
    localparam tick_mom_t TICK_MOM_RESET = '{sum: '0, square_sum: '0, least: '1, most: '0};

    function automatic byte_mom_t byte_mom_add(input byte_mom_t m,
                                               input logic [BYTES_W-1:0] v,
                                               input logic [BYTES_SQ_W-1:0] v_sq);
        byte_mom_t r;
        r = m;
        r.sum = m.sum + VALUE_W'(v);
        r.square_sum = m.square_sum + VALUE_W'(v_sq);
        if (v < m.least)
        begin
            r.least = v;
        end
        if (v > m.most)
        begin
            r.most = v;
        end
        return r;
    endfunction

    function automatic tick_mom_t tick_mom_add(input tick_mom_t m,
                                               input logic [TICKS_W-1:0] v,
                                               input logic [TICKS_SQ_W-1:0] v_sq);
        tick_mom_t r;
        r = m;
        r.sum = m.sum + VALUE_W'(v);
        r.square_sum = m.square_sum + v_sq;
        if (v < m.least)
        begin
            r.least = v;
        end
        if (v > m.most)
        begin
            r.most = v;
        end
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] mom_pick(input logic [VALUE_W-1:0] sum,
                                                    input logic [VALUE_W-1:0] square_sum,
                                                    input logic [VALUE_W-1:0] least,
                                                    input logic [VALUE_W-1:0] most,
                                                    input logic [1:0] which);
        logic [VALUE_W-1:0] r;
        case (which)
            MOM_SUM:        r = sum;
            MOM_SQUARE_SUM: r = square_sum;
            MOM_LEAST:      r = least;
            default:        r = most;
        endcase
        return r;
    endfunction

endpackage

>>> sv/cls_front.sv
// ----------------------------------------------------------------------------
// cls_front: event intake and interval measurement
// Accepts items, keeps the per-slot start times, measures the interval,
// squares it and the byte count, and finds the rounded histogram bin.
// ----------------------------------------------------------------------------
module cls_front
    import cls_pkg::*;
#(
    parameter int CALL_SLOTS = DEF_CALL_SLOTS,
    parameter int HIST_BINS  = DEF_HIST_BINS,
    parameter int BIN_WIDTH  = DEF_BIN_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hold,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [SLOT_W-1:0]   call_slot,
    input  logic [TICKS_W-1:0]  now_ticks,
    input  logic [BYTES_W-1:0]  byte_count,
    input  logic [KIND_W-1:0]   response_kind,
    input  logic [SEL_W-1:0]    stat_select,
    input  logic                queue_full,
    output logic                push,
    output op_t                 push_data
);

    localparam int SLOT_SPAN = 1 << SLOT_W;
    localparam int SLOT_D    = (CALL_SLOTS < SLOT_SPAN) ? CALL_SLOTS : SLOT_SPAN;
    localparam int SLOT_AW   = $clog2(SLOT_D);

    // Below LIM ticks the bin is computed; at or above it the bin saturates.
    localparam longint unsigned LIM = 64'(HIST_BINS) * 64'(BIN_WIDTH);
    localparam int LIM_W   = $clog2(LIM);
    localparam int WS      = $clog2(BIN_WIDTH);
    localparam int SHIFT   = LIM_W + WS;
    localparam int RECIP_W = LIM_W + 2;
    localparam int PROD_W  = LIM_W + RECIP_W;
    localparam int BIN_AW  = $clog2(HIST_BINS);
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + 64'(BIN_WIDTH) - 64'd1) / 64'(BIN_WIDTH);

    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);
    localparam logic [TICKS_W-1:0] LIM_T    = TICKS_W'(LIM);
    localparam logic [LIM_W-1:0]   W_L      = LIM_W'(BIN_WIDTH);
    localparam logic [LIM_W:0]     W2_L     = (LIM_W + 1)'(BIN_WIDTH);
    localparam logic [BIN_AW:0]    LAST_BIN = (BIN_AW + 1)'(HIST_BINS - 1);

    logic [SLOT_AW-1:0] slot_map [SLOT_SPAN];
    logic [SLOT_AW-1:0] slot_idx;
    logic               advance;
    logic               accept;

    logic [TICKS_W-1:0] send_mem_reg [SLOT_D];
    logic [TICKS_W-1:0] recv_mem_reg [SLOT_D];
    logic [TICKS_W-1:0] send_rd_reg;
    logic [TICKS_W-1:0] recv_rd_reg;

    logic                f1_valid_reg;
    logic [ACTION_W-1:0] f1_action_reg;
    logic [TICKS_W-1:0]  f1_now_reg;
    logic [BYTES_W-1:0]  f1_bytes_reg;
    logic [KIND_W-1:0]   f1_kind_reg;
    logic [SEL_W-1:0]    f1_sel_reg;

    logic                f2_valid_reg;
    logic [ACTION_W-1:0] f2_action_reg;
    logic [TICKS_W-1:0]  f2_dt_reg;
    logic [TICKS_W-1:0]  f2_dt_next;
    logic                f2_sat_reg;
    logic [BYTES_W-1:0]  f2_bytes_reg;
    logic [KIND_W-1:0]   f2_kind_reg;
    logic [SEL_W-1:0]    f2_sel_reg;

    logic                  f3_valid_reg;
    logic [ACTION_W-1:0]   f3_action_reg;
    logic [TICKS_W-1:0]    f3_dt_reg;
    logic                  f3_sat_reg;
    logic [PROD_W-1:0]     f3_prod_reg;
    logic [TICKS_SQ_W-1:0] f3_dt_sq_reg;
    logic [BYTES_W-1:0]    f3_bytes_reg;
    logic [BYTES_SQ_W-1:0] f3_bytes_sq_reg;
    logic [KIND_W-1:0]     f3_kind_reg;
    logic [SEL_W-1:0]      f3_sel_reg;

    logic        f4_valid_reg;
    op_t         f4_reg;
    op_t         f4_next;

    logic [BIN_AW-1:0] quot;
    logic [LIM_W-1:0]  quot_w;
    logic [LIM_W-1:0]  rem;
    logic [LIM_W:0]    rem2;
    logic              round_up;
    logic [BIN_AW:0]   bin_round;
    logic [BIN_AW:0]   bin_clamp;

    for (genvar g = 0; g < SLOT_SPAN; g++)
    begin : g_slot_map
        assign slot_map[g] = SLOT_AW'(g % CALL_SLOTS);
    end

    assign slot_idx = slot_map[call_slot];
    assign advance  = !f4_valid_reg || !queue_full;
    assign in_ready = advance && !hold;
    assign accept   = in_valid && in_ready;
    assign push     = f4_valid_reg && !queue_full;
    assign push_data = f4_reg;

    // Write and read at the accept edge, so a later item always sees the
    // start time an earlier item stored.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (action == ACT_SEND_START)
            begin
                send_mem_reg[slot_idx] <= now_ticks;
            end
            if (action == ACT_RECV_START)
            begin
                recv_mem_reg[slot_idx] <= now_ticks;
            end
            send_rd_reg <= send_mem_reg[slot_idx];
            recv_rd_reg <= recv_mem_reg[slot_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    assign f2_dt_next = f1_now_reg -
                        ((f1_action_reg == ACT_RECV_STOP) ? recv_rd_reg : send_rd_reg);

    // Bin = dt / BIN_WIDTH by reciprocal, exact for every dt below LIM.
    assign quot      = f3_prod_reg[SHIFT +: BIN_AW];
    assign quot_w    = LIM_W'(quot) * W_L;
    assign rem       = f3_dt_reg[LIM_W-1:0] - quot_w;
    assign rem2      = {rem, 1'b0};
    assign round_up  = (rem2 > W2_L) || ((rem2 == W2_L) && quot[0]);
    assign bin_round = (BIN_AW + 1)'(quot) + (BIN_AW + 1)'(round_up);
    assign bin_clamp = (f3_sat_reg || (bin_round > LAST_BIN)) ? LAST_BIN : bin_round;

    always_comb
    begin
        f4_next.action   = f3_action_reg;
        f4_next.dt       = f3_dt_reg;
        f4_next.dt_sq    = f3_dt_sq_reg;
        f4_next.bytes    = f3_bytes_reg;
        f4_next.bytes_sq = f3_bytes_sq_reg;
        f4_next.kind     = f3_kind_reg;
        f4_next.sel      = f3_sel_reg;
        f4_next.bin      = BIN_IDX_W'(bin_clamp);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_action_reg <= action;
            f1_now_reg    <= now_ticks;
            f1_bytes_reg  <= byte_count;
            f1_kind_reg   <= response_kind;
            f1_sel_reg    <= stat_select;

            f2_action_reg <= f1_action_reg;
            f2_dt_reg     <= f2_dt_next;
            f2_sat_reg    <= (f2_dt_next >= LIM_T);
            f2_bytes_reg  <= f1_bytes_reg;
            f2_kind_reg   <= f1_kind_reg;
            f2_sel_reg    <= f1_sel_reg;

            f3_action_reg   <= f2_action_reg;
            f3_dt_reg       <= f2_dt_reg;
            f3_sat_reg      <= f2_sat_reg;
            f3_prod_reg     <= PROD_W'(f2_dt_reg[LIM_W-1:0]) * PROD_W'(RECIP);
            f3_dt_sq_reg    <= TICKS_SQ_W'(f2_dt_reg) * TICKS_SQ_W'(f2_dt_reg);
            f3_bytes_reg    <= f2_bytes_reg;
            f3_bytes_sq_reg <= BYTES_SQ_W'(f2_bytes_reg) * BYTES_SQ_W'(f2_bytes_reg);
            f3_kind_reg     <= f2_kind_reg;
            f3_sel_reg      <= f2_sel_reg;

            f4_reg <= f4_next;
        end
    end

endmodule

>>> sv/cls_queue.sv
// ----------------------------------------------------------------------------
// cls_queue: short queue between the front and the back
// A small first-in first-out buffer of measured items.
// ----------------------------------------------------------------------------
module cls_queue
    import cls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> sv/cls_back.sv
// ----------------------------------------------------------------------------
// cls_back: statistics update and readout
// Folds each measured item into the running statistics, the response-time
// histogram and the kind counters, and registers the result value.
// ----------------------------------------------------------------------------
module cls_back
    import cls_pkg::*;
#(
    parameter int HIST_BINS      = DEF_HIST_BINS,
    parameter int RESPONSE_KINDS = DEF_RESPONSE_KINDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  op_t                head,
    output logic               pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] value
);

    localparam int BIN_AW  = $clog2(HIST_BINS);
    localparam int KIND_AW = (RESPONSE_KINDS > 1) ? $clog2(RESPONSE_KINDS) : 1;
    localparam int CLR_N   = (HIST_BINS > RESPONSE_KINDS) ? HIST_BINS : RESPONSE_KINDS;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

    logic [VALUE_W-1:0] bin_mem_reg  [HIST_BINS];
    logic [VALUE_W-1:0] kind_mem_reg [RESPONSE_KINDS];

    logic               clr_busy_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;

    logic               b1_valid_reg;
    op_t                b1_reg;
    logic               b1_done;
    logic [BIN_AW-1:0]  bin_addr_reg;
    logic [BIN_AW-1:0]  bin_addr_next;
    logic               bin_hit_reg;
    logic               bin_hit_next;
    logic [VALUE_W-1:0] bin_rd_reg;
    logic [KIND_AW-1:0] kind_addr_reg;
    logic [KIND_AW-1:0] kind_addr_next;
    logic               kind_hit_reg;
    logic               kind_hit_next;
    logic [VALUE_W-1:0] kind_rd_reg;

    logic [BIN_IDX_W-1:0]  bin_sel_idx;
    logic [KIND_SEL_W-1:0] kind_sel_idx;
    logic [KIND_SEL_W-1:0] kind_idx;

    logic               bin_we;
    logic [BIN_AW-1:0]  bin_waddr;
    logic [VALUE_W-1:0] bin_wdata;
    logic               kind_we;
    logic [KIND_AW-1:0] kind_waddr;
    logic [VALUE_W-1:0] kind_wdata;

    logic [VALUE_W-1:0] request_total_reg;
    logic [VALUE_W-1:0] response_total_reg;
    byte_mom_t          req_bytes_reg;
    tick_mom_t          req_xfer_reg;
    tick_mom_t          resp_time_reg;
    byte_mom_t          rsp_bytes_reg;
    tick_mom_t          rsp_xfer_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         which;

    assign clearing  = clr_busy_reg;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    assign b1_done = b1_valid_reg && (!out_valid_reg || out_ready);
    assign pop     = head_valid && (!b1_valid_reg || b1_done);

    // Memory addresses come from the queue head so the read data is ready
    // once the item sits in the execute register.
    assign bin_sel_idx  = BIN_IDX_W'(head.sel - SEL_BIN_BASE);
    assign kind_sel_idx = KIND_SEL_W'(head.sel - SEL_KIND_BASE);
    assign kind_idx     = (head.action == ACT_RECV_STOP) ? KIND_SEL_W'(head.kind) : kind_sel_idx;

    always_comb
    begin
        if (head.action == ACT_RECV_START)
        begin
            bin_addr_next = head.bin[BIN_AW-1:0];
            bin_hit_next  = 1'b1;
        end
        else
        begin
            bin_addr_next = bin_sel_idx[BIN_AW-1:0];
            bin_hit_next  = (head.action == ACT_READ) &&
                            (head.sel inside {[SEL_BIN_BASE:SEL_BIN_END]}) &&
                            (32'(bin_sel_idx) < 32'(HIST_BINS));
        end
        kind_addr_next = kind_idx[KIND_AW-1:0];
        kind_hit_next  = ((head.action == ACT_RECV_STOP) ||
                          ((head.action == ACT_READ) &&
                           (head.sel inside {[SEL_KIND_BASE:SEL_KIND_END]}))) &&
                         (32'(kind_idx) < 32'(RESPONSE_KINDS));
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            bin_we     = (32'(clr_cnt_reg) < 32'(HIST_BINS));
            bin_waddr  = clr_cnt_reg[BIN_AW-1:0];
            bin_wdata  = '0;
            kind_we    = (32'(clr_cnt_reg) < 32'(RESPONSE_KINDS));
            kind_waddr = clr_cnt_reg[KIND_AW-1:0];
            kind_wdata = '0;
        end
        else
        begin
            bin_we     = b1_done && (b1_reg.action == ACT_RECV_START);
            bin_waddr  = bin_addr_reg;
            bin_wdata  = bin_rd_reg + VALUE_W'(1);
            kind_we    = b1_done && (b1_reg.action == ACT_RECV_STOP) && kind_hit_reg;
            kind_waddr = kind_addr_reg;
            kind_wdata = kind_rd_reg + VALUE_W'(1);
        end
    end

    // The read register takes the value being written at the same edge, so
    // back-to-back updates of one counter never lose a count.
    always_ff @(posedge clk)
    begin
        if (pop && bin_hit_next)
        begin
            if (bin_we && (bin_waddr == bin_addr_next))
            begin
                bin_rd_reg <= bin_wdata;
            end
            else
            begin
                bin_rd_reg <= bin_mem_reg[bin_addr_next];
            end
        end
        if (bin_we)
        begin
            bin_mem_reg[bin_waddr] <= bin_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && kind_hit_next)
        begin
            if (kind_we && (kind_waddr == kind_addr_next))
            begin
                kind_rd_reg <= kind_wdata;
            end
            else
            begin
                kind_rd_reg <= kind_mem_reg[kind_addr_next];
            end
        end
        if (kind_we)
        begin
            kind_mem_reg[kind_waddr] <= kind_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_reg        <= head;
            bin_addr_reg  <= bin_addr_next;
            bin_hit_reg   <= bin_hit_next;
            kind_addr_reg <= kind_addr_next;
            kind_hit_reg  <= kind_hit_next;
        end
        if (b1_done)
        begin
            value_reg <= value_next;
        end
    end

    always_comb
    begin
        which = 2'(b1_reg.sel);
        if (b1_reg.sel == SEL_REQ_TOTAL)
        begin
            read_value = request_total_reg;
        end
        else if (b1_reg.sel inside {[SEL_REQ_BYTES:SEL_REQ_BYTES + SEL_GROUP_END]})
        begin
            which = 2'(b1_reg.sel - SEL_REQ_BYTES);
            read_value = mom_pick(req_bytes_reg.sum, req_bytes_reg.square_sum,
                                  VALUE_W'(req_bytes_reg.least),
                                  VALUE_W'(req_bytes_reg.most), which);
        end
        else if (b1_reg.sel inside {[SEL_REQ_XFER:SEL_REQ_XFER + SEL_GROUP_END]})
        begin
            which = 2'(b1_reg.sel - SEL_REQ_XFER);
            read_value = mom_pick(req_xfer_reg.sum, req_xfer_reg.square_sum,
                                  VALUE_W'(req_xfer_reg.least),
                                  VALUE_W'(req_xfer_reg.most), which);
        end
        else if (b1_reg.sel inside {[SEL_RESP_TIME:SEL_RESP_TIME + SEL_GROUP_END]})
        begin
            which = 2'(b1_reg.sel - SEL_RESP_TIME);
            read_value = mom_pick(resp_time_reg.sum, resp_time_reg.square_sum,
                                  VALUE_W'(resp_time_reg.least),
                                  VALUE_W'(resp_time_reg.most), which);
        end
        else if (b1_reg.sel == SEL_RSP_TOTAL)
        begin
            read_value = response_total_reg;
        end
        else if (b1_reg.sel inside {[SEL_RSP_BYTES:SEL_RSP_BYTES + SEL_GROUP_END]})
        begin
            which = 2'(b1_reg.sel - SEL_RSP_BYTES);
            read_value = mom_pick(rsp_bytes_reg.sum, rsp_bytes_reg.square_sum,
                                  VALUE_W'(rsp_bytes_reg.least),
                                  VALUE_W'(rsp_bytes_reg.most), which);
        end
        else if (b1_reg.sel inside {[SEL_RSP_XFER:SEL_RSP_XFER + SEL_GROUP_END]})
        begin
            which = 2'(b1_reg.sel - SEL_RSP_XFER);
            read_value = mom_pick(rsp_xfer_reg.sum, rsp_xfer_reg.square_sum,
                                  VALUE_W'(rsp_xfer_reg.least),
                                  VALUE_W'(rsp_xfer_reg.most), which);
        end
        else if (b1_reg.sel inside {[SEL_BIN_BASE:SEL_BIN_END]})
        begin
            read_value = bin_hit_reg ? bin_rd_reg : '0;
        end
        else if (b1_reg.sel inside {[SEL_KIND_BASE:SEL_KIND_END]})
        begin
            read_value = kind_hit_reg ? kind_rd_reg : '0;
        end
        else
        begin
            read_value = '0;
        end
    end

    always_comb
    begin
        case (b1_reg.action)
            ACT_SEND_STOP:  value_next = VALUE_W'(b1_reg.dt);
            ACT_RECV_START: value_next = VALUE_W'(b1_reg.dt);
            ACT_RECV_STOP:  value_next = VALUE_W'(b1_reg.dt);
            ACT_READ:       value_next = read_value;
            default:        value_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (pop)
            begin
                b1_valid_reg <= 1'b1;
            end
            else if (b1_done)
            begin
                b1_valid_reg <= 1'b0;
            end
            if (b1_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_total_reg  <= '0;
            response_total_reg <= '0;
            req_bytes_reg      <= BYTE_MOM_RESET;
            req_xfer_reg       <= TICK_MOM_RESET;
            resp_time_reg      <= TICK_MOM_RESET;
            rsp_bytes_reg      <= BYTE_MOM_RESET;
            rsp_xfer_reg       <= TICK_MOM_RESET;
        end
        else if (b1_done)
        begin
            case (b1_reg.action)
                ACT_SEND_STOP:
                begin
                    request_total_reg <= request_total_reg + VALUE_W'(1);
                    req_bytes_reg <= byte_mom_add(req_bytes_reg, b1_reg.bytes, b1_reg.bytes_sq);
                    req_xfer_reg  <= tick_mom_add(req_xfer_reg, b1_reg.dt, b1_reg.dt_sq);
                end
                ACT_RECV_START:
                begin
                    resp_time_reg <= tick_mom_add(resp_time_reg, b1_reg.dt, b1_reg.dt_sq);
                end
                ACT_RECV_STOP:
                begin
                    response_total_reg <= response_total_reg + VALUE_W'(1);
                    rsp_bytes_reg <= byte_mom_add(rsp_bytes_reg, b1_reg.bytes, b1_reg.bytes_sq);
                    rsp_xfer_reg  <= tick_mom_add(rsp_xfer_reg, b1_reg.dt, b1_reg.dt_sq);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> sv/call_latency_statistics.sv
// ----------------------------------------------------------------------------
// call_latency_statistics: call latency statistics monitor
// Measures send and receive intervals of tagged calls and keeps running
// statistics, a response-time histogram and response kind counts.
// ----------------------------------------------------------------------------
// Usage: each input item is one call event (send start, send stop, receive
// start, receive stop) or a read of one statistic, moved by in_valid and
// in_ready. Every accepted item gives exactly one item on the output
// channel (out_valid, out_ready, value): the measured interval, the read
// statistic, or zero.
// Throughput is one item per cycle while the output is not stalled and
// no clear sweep runs. From the accept edge to out_valid an item passes
// four front stages (start-time memory read, interval subtract,
// reciprocal and square multipliers, bin rounding), then the queue and
// the statistics update stage. After reset the histogram and kind
// counters are swept to zero, one entry a cycle, and in_ready stays low
// meanwhile. When the receiver stalls, the output register holds its
// item, the update stage and the four-entry queue fill, and then the
// front stops and in_ready falls.
// ----------------------------------------------------------------------------
module call_latency_statistics
    import cls_pkg::*;
#(
    parameter int CALL_SLOTS     = DEF_CALL_SLOTS,
    parameter int HIST_BINS      = DEF_HIST_BINS,
    parameter int BIN_WIDTH      = DEF_BIN_WIDTH,
    parameter int RESPONSE_KINDS = DEF_RESPONSE_KINDS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [SLOT_W-1:0]   call_slot,
    input  logic [TICKS_W-1:0]  now_ticks,
    input  logic [BYTES_W-1:0]  byte_count,
    input  logic [KIND_W-1:0]   response_kind,
    input  logic [SEL_W-1:0]    stat_select,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VALUE_W-1:0]  value
);

    logic clearing;
    logic queue_full;
    logic push;
    op_t  push_data;
    logic pop;
    logic head_valid;
    op_t  head;

    cls_front #(
        .CALL_SLOTS (CALL_SLOTS),
        .HIST_BINS  (HIST_BINS),
        .BIN_WIDTH  (BIN_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (clearing),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .call_slot     (call_slot),
        .now_ticks     (now_ticks),
        .byte_count    (byte_count),
        .response_kind (response_kind),
        .stat_select   (stat_select),
        .queue_full    (queue_full),
        .push          (push),
        .push_data     (push_data)
    );

    cls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cls_back #(
        .HIST_BINS      (HIST_BINS),
        .RESPONSE_KINDS (RESPONSE_KINDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value)
    );

endmodule
